// ===== rtl/mgt_pkg.sv =====
// shared types and constants of the multicast group table
package mgt_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_MEMBER = 2'd3;

  // command codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_JOIN   = 1'b1;

  // all-systems group 224.0.0.1 and the multicast prefix
  localparam logic [ADDR_W-1:0] ALL_SYSTEMS_ADDR = 32'hE000_0001;
  localparam logic [3:0]        MCAST_NIBBLE     = 4'hE;

  // controller to datapath
  typedef struct packed {
    logic start;   // latch item, clear scan state
    logic scan;    // read one slot, advance the slot counter
    logic commit;  // load result register, store a new group
  } mgt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // slot counter points at the last slot
    logic out_free;   // result register can take a beat this cycle
  } mgt_sts_t;

endpackage

// ===== rtl/mgt_if.sv =====
// valid/ready channel interfaces for request and result beats
interface mgt_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] group_address;

  modport source (output valid, output command, output group_address, input ready);
  modport sink (input valid, input command, input group_address, output ready);
endinterface

interface mgt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  slot_index;
  logic        announce_join;
  logic [31:0] announce_address;

  modport source (output valid, output status, output slot_index, output announce_join,
                  output announce_address, input ready);
  modport sink (input valid, input status, input slot_index, input announce_join,
                input announce_address, output ready);
endinterface

// ===== rtl/mgt_ctrl.sv =====
// control state machine: accept, scan slots, drain compare, decide
module mgt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mgt_pkg::mgt_sts_t sts,
  output mgt_pkg::mgt_cmd_t cmd
);
  import mgt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.start  = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.commit = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/mgt_dp.sv =====
// datapath: slot memory, scan compare, decision and result register
module mgt_dp #(
  parameter int unsigned GROUP_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mgt_pkg::mgt_cmd_t cmd,
  output mgt_pkg::mgt_sts_t sts,
  input  logic              in_command,
  input  logic [31:0]       in_group_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [2:0]        out_slot_index,
  output logic              out_announce_join,
  output logic [31:0]       out_announce_address
);
  import mgt_pkg::*;

  localparam int unsigned IDX_W = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GROUP_SLOTS - 1);

  logic [ADDR_W-1:0]      mem [GROUP_SLOTS];
  logic [GROUP_SLOTS-1:0] vld_r;

  logic              item_cmd_r;
  logic [ADDR_W-1:0] item_addr_r;
  logic [IDX_W-1:0]  cnt_r;

  logic [ADDR_W-1:0] rd_data_r;
  logic              rd_slot_vld_r;
  logic              cmp_en_r;
  logic [IDX_W-1:0]  cmp_idx_r;

  logic              hit_found_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic              free_found_r;
  logic [IDX_W-1:0]  free_idx_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_ann_r;
  logic [ADDR_W-1:0]   out_addr_r;

  logic [ADDR_W-1:0]   entry;
  logic                addr_bad;
  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_idx;
  logic                res_ok;
  logic                res_store;
  logic [31:0]         res_idx_ext;

  assign sts.scan_last = (cnt_r == LAST_IDX);
  assign sts.out_free  = !out_valid_r || out_ready;

  // never-written slots read as free
  assign entry = rd_slot_vld_r ? rd_data_r : '0;

  assign addr_bad = (item_addr_r[ADDR_W-1 -: 4] != MCAST_NIBBLE) ||
                    (item_addr_r == ALL_SYSTEMS_ADDR);

  always_comb begin
    res_status = ST_OK;
    res_idx    = '0;
    res_ok     = 1'b0;
    res_store  = 1'b0;
    priority if (item_cmd_r == OP_LOOKUP) begin
      if (hit_found_r) begin
        res_ok  = 1'b1;
        res_idx = hit_idx_r;
      end else begin
        res_status = ST_NOT_MEMBER;
      end
    end else if (addr_bad) begin
      res_status = ST_INVALID;
    end else if (hit_found_r) begin
      res_ok  = 1'b1;
      res_idx = hit_idx_r;
    end else if (free_found_r) begin
      res_ok    = 1'b1;
      res_idx   = free_idx_r;
      res_store = 1'b1;
    end else begin
      res_status = ST_FULL;
    end
  end

  assign res_idx_ext = 32'(res_idx);

  // slot memory
  always_ff @(posedge clk) begin
    if (cmd.commit && res_store) begin
      mem[free_idx_r] <= item_addr_r;
    end
    if (cmd.scan) begin
      rd_data_r <= mem[cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.commit && res_store) begin
      vld_r[free_idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_slot_vld_r <= vld_r[cnt_r];
      cmp_idx_r     <= cnt_r;
    end
    if (cmd.start) begin
      item_cmd_r  <= in_command;
      item_addr_r <= in_group_address;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      cmp_en_r     <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      hit_idx_r    <= '0;
      free_idx_r   <= '0;
    end else begin
      cmp_en_r <= cmd.scan;
      if (cmd.start) begin
        cnt_r        <= '0;
        hit_found_r  <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        if (cmd.scan) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (cmp_en_r) begin
          if (!hit_found_r && entry == item_addr_r) begin
            hit_found_r <= 1'b1;
            hit_idx_r   <= cmp_idx_r;
          end
          if (!free_found_r && entry == '0) begin
            free_found_r <= 1'b1;
            free_idx_r   <= cmp_idx_r;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_slot_r   <= res_ok ? res_idx_ext[SLOT_W-1:0] : '0;
      out_ann_r    <= res_store;
      out_addr_r   <= res_store ? item_addr_r : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_slot_index       = out_slot_r;
  assign out_announce_join    = out_ann_r;
  assign out_announce_address = out_addr_r;

endmodule

// ===== rtl/multicast_group_table_core.sv =====
// top level of the multicast group membership table
// a result beat is offered after all slots are scanned, the compare stage drains and
// the decide state commits once the result register is free; requests are taken one at
// a time, only in idle, paced by the one-slot-per-cycle scan of the single-port memory
// the result register lets the next request in while a result waits to be taken
// reset: synchronous, active low; all slots read as free right after reset
module multicast_group_table_core #(
  parameter int unsigned GROUP_SLOTS = 8
) (
  input  logic  clk,
  input  logic  rst_n,
  mgt_in_if.sink    in_ch,
  mgt_out_if.source out_ch
);
  import mgt_pkg::*;

  // command and status between control and datapath
  mgt_cmd_t cmd;
  mgt_sts_t sts;

  // sequencer: idle -> scan every slot -> drain the compare stage -> decide
  mgt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot memory with per-slot valid bits, first-hit and first-free tracking,
  // result register feeding the out channel
  mgt_dp #(
    .GROUP_SLOTS (GROUP_SLOTS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_command           (in_ch.command),
    .in_group_address     (in_ch.group_address),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_status           (out_ch.status),
    .out_slot_index       (out_ch.slot_index),
    .out_announce_join    (out_ch.announce_join),
    .out_announce_address (out_ch.announce_address)
  );

  // an announced group is always a valid multicast address
  a_ann_addr_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.announce_join) |->
      (out_ch.announce_address[31:28] == MCAST_NIBBLE &&
       out_ch.announce_address != ALL_SYSTEMS_ADDR))
    else $error("announced address is not a joinable group");

  // failed requests carry no slot and no announce
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |->
      (out_ch.slot_index == '0 && !out_ch.announce_join && out_ch.announce_address == '0))
    else $error("failed request carries slot or announce");

  // no address is reported without an announce
  a_addr_needs_ann: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.announce_join) |-> (out_ch.announce_address == '0))
    else $error("announce address without announce");

  // a request beat starts a scan, so the request side closes next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (!in_ch.ready && cmd.scan))
    else $error("scan did not start after request beat");

endmodule
